[rtl/adam_pkg.sv]
// shared types and constants for the adam / sgd parameter update block
`timescale 1ns / 1ps
package adam_pkg;
    localparam int QSHIFT = 24;
    localparam int WORD_WIDTH = 32;
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_APPLY = 2'd1;
    localparam logic [1:0] OP_PASS  = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;
    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_LR   = 3'd1;
    localparam logic [2:0] REG_B1   = 3'd2;
    localparam logic [2:0] REG_B2   = 3'd3;
    localparam logic [2:0] REG_EPS  = 3'd4;
    localparam logic [24:0] Q_ONE   = 25'h1000000;
endpackage

[rtl/adam_ram.sv]
// generic single port write, single port read ram with registered read
`timescale 1ns / 1ps
module adam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

[rtl/adam_divsqrt.sv]
// shared multicycle unsigned restoring divider and bitwise integer square root
`timescale 1ns / 1ps
module adam_divsqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_is_sqrt,
    input  logic [79:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [79:0] o_quo
);
    logic [79:0] r_q, n_q;
    logic [80:0] r_rem, n_rem;
    logic [81:0] r_x, n_x;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_sqrt, n_sqrt, r_done, n_done;
    logic [63:0] r_den, n_den;
    logic [81:0] w_trial;
    logic [81:0] w_shr;
    // one quotient or root bit per cycle
    always_comb begin
        n_q = r_q; n_rem = r_rem; n_x = r_x; n_cnt = r_cnt; n_busy = r_busy;
        n_sqrt = r_sqrt; n_den = r_den; n_done = 1'b0;
        w_trial = '0; w_shr = '0;
        if (i_start) begin
            n_busy = 1'b1; n_sqrt = i_is_sqrt; n_den = i_den;
            n_q = i_num; n_rem = '0; n_x = '0;
            n_cnt = i_is_sqrt ? 7'd40 : 7'd80;
        end else if (r_busy) begin
            if (r_sqrt) begin
                // r_q holds radicand, two bits a step; r_x is remainder
                w_shr = {r_x[79:0], r_q[79:78]};
                w_trial = {r_rem[79:0], 2'b01};
                n_q = {r_q[77:0], 2'b00};
                if (w_shr >= w_trial) begin
                    n_x = w_shr - w_trial;
                    n_rem = {r_rem[79:0], 1'b1};
                end else begin
                    n_x = w_shr;
                    n_rem = {r_rem[79:0], 1'b0};
                end
            end else begin
                w_shr = {r_rem, r_q[79]};
                if (w_shr >= {18'd0, r_den}) begin
                    n_rem = 81'(w_shr - {18'd0, r_den});
                    n_q = {r_q[78:0], 1'b1};
                end else begin
                    n_rem = w_shr[80:0];
                    n_q = {r_q[78:0], 1'b0};
                end
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem; r_x <= n_x; r_sqrt <= n_sqrt; r_den <= n_den;
    end
    assign o_done = r_done;
    assign o_quo  = r_sqrt ? {1'b0, r_rem[78:0]} : r_q;
endmodule

[rtl/adam_sgd_parameter_update.sv]
// top level: parameter table with adam moments and the update sequencer
// adam apply runs three 80-step divisions and a 40-step root on one shared unit
// one item at a time; the next input is taken in the cycle after the output transfer; pass gives no output
// reset: synchronous active low; config registers to defaults, step count 0, powers 1.0; tables undefined
`timescale 1ns / 1ps
module adam_sgd_parameter_update #(
    parameter int NUM_PARAMS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // operation[1:0], param_index[13:2], operand_value[45:14]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_index[11:0], new_value[43:12], saturated[44]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
    localparam logic signed [63:0] WMAX = (64'sd1 <<< (adam_pkg::WORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;
    localparam logic [3:0] S_IDLE = 4'd0, S_READ = 4'd1, S_MUL = 4'd2, S_MOM = 4'd3,
        S_DIV1 = 4'd4, S_DIV2 = 4'd5, S_SQRT = 4'd6, S_DEN = 4'd7, S_MULS = 4'd8,
        S_DIV3 = 4'd9, S_FIN = 4'd10, S_OUT = 4'd11, S_PASS = 4'd12;

    // configuration registers
    logic        r_mode;
    logic [24:0] r_lr, r_eps, r_p1, r_p2;
    logic [23:0] r_b1, r_b2;
    logic [31:0] r_steps;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1; r_lr <= 25'd16777; r_b1 <= 24'd15099494;
            r_b2 <= 24'd16760439; r_eps <= 25'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                adam_pkg::REG_MODE: r_mode <= i_cfg_data[0];
                adam_pkg::REG_LR:   r_lr   <= i_cfg_data[24:0];
                adam_pkg::REG_B1:   r_b1   <= i_cfg_data[23:0];
                adam_pkg::REG_B2:   r_b2   <= i_cfg_data[23:0];
                adam_pkg::REG_EPS:  r_eps  <= i_cfg_data[24:0];
                default: ;
            endcase
        end
    end

    // sequencer registers
    logic [3:0]  r_state;
    logic [1:0]  r_op;
    logic [AW-1:0] r_idx;
    logic [11:0] r_oidx;
    logic signed [31:0] r_g;
    logic signed [63:0] r_p, r_m, r_res;
    logic [63:0] r_v, r_g2, r_den;
    logic signed [63:0] r_mh;
    logic signed [79:0] r_acc;
    logic        r_sat, r_neg;
    logic [47:0] r_out;

    // memories
    logic [adam_pkg::WORD_WIDTH-1:0] w_pq, w_pw;
    logic [31:0] w_mq, w_vq;
    logic        w_we;
    adam_ram #(.WIDTH(adam_pkg::WORD_WIDTH), .DEPTH(NUM_PARAMS)) u_par (.i_clk(i_clk),
        .i_we(w_we), .i_waddr(r_idx), .i_wdata(w_pw), .i_raddr(r_idx), .o_rdata(w_pq));
    adam_ram #(.WIDTH(32), .DEPTH(NUM_PARAMS)) u_m1 (.i_clk(i_clk), .i_we(w_we),
        .i_waddr(r_idx), .i_wdata(r_m[31:0]), .i_raddr(r_idx), .o_rdata(w_mq));
    adam_ram #(.WIDTH(32), .DEPTH(NUM_PARAMS)) u_m2 (.i_clk(i_clk), .i_we(w_we),
        .i_waddr(r_idx), .i_wdata(r_v[31:0]), .i_raddr(r_idx), .o_rdata(w_vq));
    assign w_pw = r_res[adam_pkg::WORD_WIDTH-1:0];

    // shared divider / root
    logic        w_dstart, w_dsqrt, w_ddone;
    logic [79:0] w_dnum, w_dq;
    logic [63:0] w_dden;
    adam_divsqrt u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_is_sqrt(w_dsqrt), .i_num(w_dnum), .i_den(w_dden), .o_done(w_ddone), .o_quo(w_dq));

    logic w_in_acc, w_out_acc;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = r_out;

    logic [63:0] w_d1, w_d2, w_mabs, w_rden;
    assign w_d1 = 64'(adam_pkg::Q_ONE) - 64'(r_p1);
    assign w_d2 = 64'(adam_pkg::Q_ONE) - 64'(r_p2);
    assign w_mabs = r_m[63] ? 64'(-r_m) : 64'(r_m);
    assign w_rden = w_dq[63:0] + 64'(r_eps);

    // control of the shared unit
    always_comb begin
        w_dstart = 1'b0; w_dsqrt = 1'b0; w_dnum = '0; w_dden = '0;
        case (r_state)
            S_MOM: if (r_mode && r_op == adam_pkg::OP_APPLY && w_d1 != 0 && w_d2 != 0) begin
                w_dstart = 1'b1; w_dnum = 80'({w_mabs, 24'd0}); w_dden = w_d1;
            end
            S_DIV1: if (w_ddone) begin
                w_dstart = 1'b1; w_dnum = 80'({r_v, 24'd0}); w_dden = w_d2;
            end
            S_DIV2: if (w_ddone) begin
                w_dstart = 1'b1; w_dsqrt = 1'b1;
                w_dnum = {16'd0, (w_dq > 80'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : w_dq[39:0],
                          24'd0};
            end
            S_MULS: begin
                w_dstart = 1'b1; w_dnum = r_acc[79] ? 80'(-r_acc) : 80'(r_acc); w_dden = r_den;
            end
            default: ;
        endcase
    end

    // read, modify, write sequencer
    logic signed [63:0] w_step, w_fix;
    always_comb begin
        w_step = r_mh;
        w_fix = r_p - w_step;
    end
    assign w_we = (r_state == S_FIN) && (r_op != adam_pkg::OP_PASS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_steps <= '0;
            r_p1 <= adam_pkg::Q_ONE; r_p2 <= adam_pkg::Q_ONE;
        end else begin
            case (r_state)
                S_IDLE: if (w_in_acc) begin
                    r_op <= s_axis_tdata[1:0];
                    r_oidx <= s_axis_tdata[13:2];
                    r_idx <= AW'(s_axis_tdata[13:2]);
                    r_g <= s_axis_tdata[45:14];
                    r_sat <= 1'b0;
                    if (s_axis_tdata[1:0] == adam_pkg::OP_PASS) r_state <= S_PASS;
                    else if (s_axis_tdata[1:0] == adam_pkg::OP_RSVD ||
                             32'(s_axis_tdata[13:2]) >= NUM_PARAMS) r_state <= S_IDLE;
                    else r_state <= S_READ;
                end
                S_PASS: begin
                    r_steps <= r_steps + 32'd1;
                    r_p1 <= 25'((50'(r_p1) * 50'(r_b1)) >> adam_pkg::QSHIFT);
                    r_p2 <= 25'((50'(r_p2) * 50'(r_b2)) >> adam_pkg::QSHIFT);
                    r_state <= S_IDLE;
                end
                S_READ: r_state <= S_MUL;
                S_MUL: begin
                    r_p <= 64'(signed'(w_pq));
                    // gradient squared and first moment side by side
                    r_g2 <= 64'((64'(r_g) * 64'(r_g)) >>> adam_pkg::QSHIFT);
                    if (r_op == adam_pkg::OP_LOAD) begin
                        r_m <= '0; r_v <= '0;
                        if (64'(r_g) > WMAX) begin r_res <= WMAX; r_sat <= 1'b1; end
                        else if (64'(r_g) < WMIN) begin r_res <= WMIN; r_sat <= 1'b1; end
                        else r_res <= 64'(r_g);
                        r_state <= S_FIN;
                    end else if (!r_mode) begin
                        r_m <= 64'(signed'(w_mq));
                        r_v <= 64'(w_vq);
                        r_mh <= (64'(r_g) * 64'(signed'({1'b0, r_lr}))) >>> adam_pkg::QSHIFT;
                        r_state <= S_DEN;
                    end else begin
                        r_v <= 64'(w_vq);
                        r_m <= (64'(signed'({1'b0, r_b1})) * 64'(signed'(w_mq)) +
                                (64'(signed'({1'b0, adam_pkg::Q_ONE})) -
                                 64'(signed'({1'b0, r_b1}))) * 64'(r_g)) >>> adam_pkg::QSHIFT;
                        r_state <= S_MOM;
                    end
                end
                S_MOM: begin
                    logic [63:0] g2c;
                    logic        sat_n;
                    g2c = r_g2;
                    sat_n = r_sat;
                    if (r_g2 > 64'hFFFF_FFFF) begin g2c = 64'hFFFF_FFFF; sat_n = 1'b1; end
                    r_v <= (64'(r_b2) * r_v + (64'(adam_pkg::Q_ONE) - 64'(r_b2)) * g2c)
                           >> adam_pkg::QSHIFT;
                    r_neg <= r_m[63];
                    if (w_d1 == 0 || w_d2 == 0) begin
                        r_sat <= 1'b1; r_res <= r_p; r_state <= S_FIN;
                    end else begin
                        r_sat <= sat_n; r_state <= S_DIV1;
                    end
                end
                S_DIV1: if (w_ddone) begin
                    if (w_dq > 80'h3F_FFFF_FFFF) begin
                        r_mh <= r_neg ? -64'sh3F_FFFF_FFFF : 64'sh3F_FFFF_FFFF; r_sat <= 1'b1;
                    end else r_mh <= r_neg ? -64'(w_dq[63:0]) : 64'(w_dq[63:0]);
                    r_state <= S_DIV2;
                end
                S_DIV2: if (w_ddone) begin
                    if (w_dq > 80'hFF_FFFF_FFFF) r_sat <= 1'b1;
                    r_state <= S_SQRT;
                end
                S_SQRT: if (w_ddone) begin
                    // zero denominator keeps the parameter
                    if (w_rden == 64'd0) begin
                        r_sat <= 1'b1; r_res <= r_p; r_state <= S_FIN;
                    end else begin
                        r_den <= w_rden;
                        r_acc <= 80'(signed'({1'b0, r_lr})) * 80'(r_mh);
                        r_state <= S_MULS;
                    end
                end
                S_MULS: r_state <= S_DIV3;
                S_DIV3: if (w_ddone) begin
                    if (w_dq > 80'h100_0000_0000) begin
                        r_mh <= r_acc[79] ? -64'sh100_0000_0000 : 64'sh100_0000_0000;
                        r_sat <= 1'b1;
                    end else r_mh <= r_acc[79] ? -64'(w_dq[63:0]) : 64'(w_dq[63:0]);
                    r_state <= S_DEN;
                end
                S_DEN: begin
                    // saturating subtract of the step
                    if (w_fix > WMAX) begin r_res <= WMAX; r_sat <= 1'b1; end
                    else if (w_fix < WMIN) begin r_res <= WMIN; r_sat <= 1'b1; end
                    else r_res <= w_fix;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_out <= {3'd0, r_sat, r_res[31:0], r_oidx};
                    r_state <= S_OUT;
                end
                S_OUT: if (w_out_acc) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // unused bookkeeping
    logic w_unused;
    assign w_unused = ^r_steps;

    // output valid only from the output state and input blocked while busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
    a_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> m_axis_tvalid) else $error("write without result");
endmodule
